>>> hw/rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
`default_nettype none
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [7:0]  BLANK_CODE   = 8'd32;
  localparam logic [15:0] RESET_CELL   = 16'h0720;
  localparam logic [7:0]  RESET_COLOR  = 8'h07;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic REG_COLOR = 1'b0;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcw_req_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
  } tcw_rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/text_console_writer.sv
// Text console engine: cell store, cursor, scroll, clear and cell read.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-----------------------
//   request  | in        | req_valid / req_stall  | req (tcw_req_t)
//   result   | out       | rsp_valid / rsp_stall  | rsp (tcw_rsp_t)
//   config   | in        | APB psel/penable/pwrite| pwdata, paddr[2:0]
//
// A put passes through the character state, an in-range read through read-wait,
// a clear fills every cell, and a put from the last row first scrolls the store
// up a row and blanks the last row; all writes go through the one RAM write port.
// After reset a fill pass blanks the store; no request
// is taken meanwhile. One request is in work at a time; a finished result
// waits in the output register under rsp_stall while the next request enters.
`default_nettype none
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_stall,
  input  wire tcw_pkg::tcw_req_t req,
  output logic             rsp_valid,
  input  wire              rsp_stall,
  output tcw_pkg::tcw_rsp_t rsp,
  input  wire              psel,
  input  wire              penable,
  input  wire              pwrite,
  input  wire [2:0]        paddr,
  input  wire [31:0]       pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RDWAIT = 3'd1;
  localparam logic [2:0] ST_SCROLL = 3'd2;
  localparam logic [2:0] ST_FILL   = 3'd3;
  localparam logic [2:0] ST_CHAR   = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  localparam logic [1:0] MODE_INIT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_SCROLL = 2'd2;

  logic [2:0]    state;
  logic [1:0]    mode;
  logic [AW-1:0] ptr;
  logic [AW-1:0] cur_addr;
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [7:0]    color;
  logic [7:0]    ch;
  logic [15:0]   res_data;
  logic          cp_valid;
  logic [AW-1:0] cp_addr;

  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [AW-1:0] raddr;
  logic [15:0]   rd_data;
  logic [15:0]   fill_val;
  logic          req_take;
  logic          rsp_free;
  logic          cfg_wr;

  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_COLOR);
  assign prdata = (paddr[2] == REG_COLOR) ? {24'd0, color} : 32'd0;

  assign fill_val = (mode == MODE_INIT) ? RESET_CELL : {color, BLANK_CODE};
  assign raddr    = (state == ST_SCROLL) ? AW'(ptr + AW'(COLUMNS)) : AW'(req.cell_index);

  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = {color, ch};
    if (cp_valid) begin
      we    = 1'b1;
      waddr = cp_addr;
      wdata = rd_data;
    end else if (state == ST_FILL) begin
      we    = 1'b1;
      waddr = ptr;
      wdata = fill_val;
    end else if (state == ST_CHAR && ch != NEWLINE_CODE) begin
      we = 1'b1;
    end
  end

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_cells (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      color <= RESET_COLOR;
    end else if (cfg_wr) begin
      color <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      mode      <= MODE_INIT;
      ptr       <= '0;
      cur_addr  <= '0;
      row       <= '0;
      col       <= '0;
      cp_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      cp_valid <= 1'b0;
      if (rsp_valid && !rsp_stall && state != ST_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_take) begin
            ch       <= req.char_code;
            res_data <= '0;
            priority if (req.opcode == OP_PUT) begin
              if (row == RW'(ROWS - 1)) begin
                mode  <= MODE_SCROLL;
                ptr   <= '0;
                state <= ST_SCROLL;
              end else begin
                state <= ST_CHAR;
              end
            end else if (req.opcode == OP_CLEAR) begin
              mode  <= MODE_CLEAR;
              ptr   <= '0;
              state <= ST_FILL;
            end else if (req.opcode == OP_READ && 32'(req.cell_index) < 32'(CELLS)) begin
              state <= ST_RDWAIT;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_RDWAIT: begin
          res_data <= rd_data;
          state    <= ST_DONE;
        end
        ST_SCROLL: begin
          cp_valid <= 1'b1;
          cp_addr  <= ptr;
          ptr      <= AW'(ptr + 1'b1);
          if (ptr == AW'(CELLS - COLUMNS - 1)) begin
            state <= ST_FILL;
          end
        end
        ST_FILL: begin
          if (!cp_valid) begin
            ptr <= AW'(ptr + 1'b1);
            if (ptr == AW'(CELLS - 1)) begin
              unique case (mode)
                MODE_INIT: begin
                  state <= ST_IDLE;
                end
                MODE_CLEAR: begin
                  row      <= '0;
                  col      <= '0;
                  cur_addr <= '0;
                  state    <= ST_DONE;
                end
                MODE_SCROLL: begin
                  row      <= RW'(ROWS - 2);
                  col      <= '0;
                  cur_addr <= AW'((ROWS - 2) * COLUMNS);
                  state    <= ST_CHAR;
                end
                default: begin
                  state <= ST_IDLE;
                end
              endcase
            end
          end
        end
        ST_CHAR: begin
          if (ch == NEWLINE_CODE) begin
            row      <= RW'(row + 1'b1);
            col      <= '0;
            cur_addr <= AW'(cur_addr - AW'(col) + AW'(COLUMNS));
          end else begin
            cur_addr <= AW'(cur_addr + 1'b1);
            if (col == CW'(COLUMNS - 1)) begin
              col <= '0;
              row <= RW'(row + 1'b1);
            end else begin
              col <= CW'(col + 1'b1);
            end
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (rsp_free) begin
            rsp_valid         <= 1'b1;
            rsp.cell_data     <= res_data;
            rsp.cursor_row    <= 5'(row);
            rsp.cursor_column <= 7'(col);
            state             <= ST_IDLE;
          end else begin
            rsp_valid <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    row <= RW'(ROWS - 1) && col <= CW'(COLUMNS - 1))
    else $error("cursor out of range");

  a_cursor_addr: assert property (@(posedge clk) disable iff (rst)
    32'(cur_addr) == 32'(row) * 32'(COLUMNS) + 32'(col))
    else $error("cursor address out of step with row and column");

  a_copy_state: assert property (@(posedge clk) disable iff (rst)
    cp_valid |-> (state == ST_SCROLL || state == ST_FILL))
    else $error("copy write outside scroll");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_DONE)
    else $error("result loaded outside done state");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Testbench for text_console_writer: random console traffic checked against a cell-store predictor.
`timescale 1ns / 1ps
module tb_top;
  import tcw_pkg::*;

  localparam int COLUMNS = DEF_COLUMNS;
  localparam int ROWS = DEF_ROWS;
  localparam int CELLS = ROWS * COLUMNS;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [2:0] COLOR_ADDR = {REG_COLOR, 2'b00};
  localparam int RANDOM_OPS = 600;
  localparam int HOLD_CYCLES = 2500;
  localparam int LIMIT_CYCLES = 8_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  tcw_req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  tcw_rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [15:0] screen [CELLS];
  int cur_row;
  int cur_col;
  logic [7:0] color_setting;

  tcw_req_t console_ops[$];
  tcw_rsp_t cursor_reports[$];
  tcw_rsp_t expected_report;
  int ops_queued = 0;
  int ops_taken = 0;
  int report_errors = 0;
  int send_gap = 0;
  int stall_left = 0;
  logic gaps_on = 1'b0;
  logic hold_active = 1'b0;

  text_console_writer u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #6 clk = ~clk;

  function automatic tcw_rsp_t advance_screen(tcw_req_t op_in);
    tcw_rsp_t report;
    report = '0;
    case (op_in.opcode)
      OP_PUT: begin
        if (cur_row == ROWS - 1) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {color_setting, BLANK_CODE};
          cur_row = cur_row - 1;
          cur_col = 0;
        end
        if (op_in.char_code == NEWLINE_CODE) begin
          cur_row = cur_row + 1;
          cur_col = 0;
        end else begin
          screen[cur_row * COLUMNS + cur_col] = {color_setting, op_in.char_code};
          cur_col = cur_col + 1;
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row = cur_row + 1;
          end
        end
      end
      OP_CLEAR: begin
        foreach (screen[i]) screen[i] = {color_setting, BLANK_CODE};
        cur_row = 0;
        cur_col = 0;
      end
      OP_READ: begin
        if (op_in.cell_index < CELLS) report.cell_data = screen[op_in.cell_index];
      end
      default: ;
    endcase
    report.cursor_row = 5'(cur_row);
    report.cursor_column = 7'(cur_col);
    return report;
  endfunction

  function void flag_error(string msg);
    report_errors++;
    if (report_errors <= 10) $display("ERROR %0t: %s", $time, msg);
  endfunction

  function void queue_op(logic [1:0] op, logic [7:0] ch, logic [10:0] idx);
    tcw_req_t item;
    item.opcode = op;
    item.char_code = ch;
    item.cell_index = idx;
    console_ops.push_back(item);
    ops_queued++;
  endfunction

  function automatic logic [7:0] pick_char(int newline_pct);
    if ($urandom_range(0, 99) < newline_pct) return NEWLINE_CODE;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [10:0] pick_cell();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 11'($urandom_range(CELLS, 2047));
    if (roll < 45) return 11'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
    return 11'($urandom_range(0, CELLS - 1));
  endfunction

  task automatic wait_drained();
    while (ops_taken != ops_queued || cursor_reports.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (req_valid && !req_stall) begin
        cursor_reports.push_back(advance_screen(req));
        ops_taken <= ops_taken + 1;
      end
      if (!(req_valid && req_stall)) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          req_valid <= 1'b0;
        end else if (console_ops.size() != 0) begin
          req <= console_ops.pop_front();
          req_valid <= 1'b1;
          if (gaps_on && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 6);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (cursor_reports.size() == 0) begin
          flag_error($sformatf("result with nothing pending: cell %h row %0d col %0d",
                               rsp.cell_data, rsp.cursor_row, rsp.cursor_column));
        end else begin
          expected_report = cursor_reports.pop_front();
          if (rsp.cell_data !== expected_report.cell_data ||
              rsp.cursor_row !== expected_report.cursor_row ||
              rsp.cursor_column !== expected_report.cursor_column) begin
            flag_error($sformatf("expected cell %h row %0d col %0d, got cell %h row %0d col %0d",
                                 expected_report.cell_data, expected_report.cursor_row,
                                 expected_report.cursor_column, rsp.cell_data,
                                 rsp.cursor_row, rsp.cursor_column));
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        rsp_stall <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 5);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= hold_active;
      end
    end
  end

  // hold off results long enough for the block to back up onto the request side
  initial begin
    wait (ops_taken >= 80);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
    wait (ops_taken >= 320);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int phase;
    int kind;
    int count;
    int pick;
    int random_ops;
    bit last_part;
    logic [7:0] color_next;

    foreach (screen[i]) screen[i] = RESET_CELL;
    cur_row = 0;
    cur_col = 0;
    color_setting = RESET_COLOR;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    queue_op(OP_READ, 8'h00, 11'd0);
    queue_op(OP_READ, 8'hFF, 11'(CELLS - 1));
    queue_op(OP_READ, 8'h00, 11'(CELLS));
    queue_op(OP_READ, 8'hFF, 11'h7FF);
    queue_op(OP_PUT, 8'h41, 11'h7FF);
    queue_op(OP_PUT, 8'h00, 11'h000);
    queue_op(OP_PUT, 8'hFF, 11'h555);
    queue_op(OP_PUT, NEWLINE_CODE, 11'h2AA);
    queue_op(OP_SPARE, 8'hFF, 11'h7FF);
    queue_op(OP_READ, 8'h00, 11'd0);
    queue_op(OP_READ, 8'h00, 11'd1);
    queue_op(OP_READ, 8'h00, 11'd2);
    queue_op(OP_READ, 8'h00, 11'(COLUMNS));
    queue_op(OP_PUT, 8'h7E, 11'h000);
    queue_op(OP_READ, 8'h00, 11'(COLUMNS));
    queue_op(OP_CLEAR, 8'hFF, 11'h7FF);
    queue_op(OP_READ, 8'h00, 11'd0);
    queue_op(OP_READ, 8'h00, 11'(CELLS - 1));

    gaps_on <= 1'b1;
    random_ops = 0;
    phase = 0;
    while (random_ops < RANDOM_OPS) begin
      if (phase % 3 == 1) begin
        wait_drained();
        color_next = phase == 1 ? 8'hFF : phase == 4 ? 8'h00 : 8'($urandom_range(0, 255));
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= COLOR_ADDR;
        pwdata <= {24'h0, color_next};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        color_setting = color_next;
      end
      last_part = (random_ops >= RANDOM_OPS - 60);
      gaps_on <= !last_part && ($urandom_range(0, 3) != 0);
      kind = last_part ? 0 : $urandom_range(0, 3);
      case (kind)
        0: count = $urandom_range(30, 70);
        1: count = $urandom_range(30, 50);
        2: count = $urandom_range(90, 130);
        default: count = $urandom_range(10, 20);
      endcase
      for (int n = 0; n < count; n++) begin
        pick = $urandom_range(0, 99);
        case (kind)
          0: begin
            if (pick < 82) queue_op(OP_PUT, pick_char(12), 11'($urandom));
            else queue_op(OP_READ, 8'($urandom), pick_cell());
          end
          1: begin
            if (pick < 85) queue_op(OP_PUT, pick_char(55), 11'($urandom));
            else queue_op(OP_READ, 8'($urandom), pick_cell());
          end
          2: begin
            if (pick < 90) queue_op(OP_PUT, pick_char(0), 11'($urandom));
            else queue_op(OP_READ, 8'($urandom), pick_cell());
          end
          default: begin
            case ($urandom_range(0, 3))
              0: queue_op(OP_PUT, 8'($urandom), 11'($urandom));
              1: queue_op(OP_CLEAR, 8'($urandom), 11'($urandom));
              2: queue_op(OP_READ, 8'($urandom), 11'($urandom));
              default: queue_op(OP_SPARE, 8'($urandom), 11'($urandom));
            endcase
          end
        endcase
      end
      random_ops += count;
      phase++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (report_errors == 0 && cursor_reports.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/text_console_writer.sv
tb/tb_top.sv
